### rtl/core/tea_dec_pkg.sv
// Shared types and constants for the TEA block decryption core.
package tea_dec_pkg;

    localparam logic [31:0] TEA_DELTA = 32'h9e37_79b9;

    typedef struct packed {
        logic [31:0] cipher_left;
        logic [31:0] cipher_right;
    } cipher_t;

    typedef struct packed {
        logic [31:0] plain_left;
        logic [31:0] plain_right;
    } plain_t;

    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
    } word_pair_t;

    typedef enum logic [1:0] {
        REG_KEY_WORD_0 = 2'd0,
        REG_KEY_WORD_1 = 2'd1,
        REG_KEY_WORD_2 = 2'd2,
        REG_KEY_WORD_3 = 2'd3
    } reg_idx_t;

endpackage

### rtl/core/tea_dec_half_round.sv
// One registered TEA decryption half-round stage with its own valid and ready.
module tea_dec_half_round
    import tea_dec_pkg::*;
#(
    parameter bit UPDATE_RIGHT = 1'b1
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  word_pair_t  up_data,
    output logic        down_valid,
    input  logic        down_ready,
    output word_pair_t  down_data,
    input  logic [31:0] key_shl,
    input  logic [31:0] key_shr,
    input  logic [31:0] round_sum
);

    logic        valid_reg;
    logic        valid_next;
    word_pair_t  data_reg;
    word_pair_t  data_next;
    logic [31:0] src_word;
    logic [31:0] mix_word;

    always_comb
    begin
        src_word = UPDATE_RIGHT ? up_data.left : up_data.right;
        mix_word = ((src_word << 4) + key_shl) ^ (src_word + round_sum)
                   ^ ((src_word >> 5) + key_shr);
        data_next = up_data;
        if (UPDATE_RIGHT)
        begin
            data_next.right = up_data.right - mix_word;
        end
        else
        begin
            data_next.left = up_data.left - mix_word;
        end
    end

    assign up_ready   = !valid_reg || down_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

### rtl/core/tea_block_decrypt_core.sv
// Top level of the pipelined TEA block decryption core with its key registers.
//
// Usage: ciphertext items enter on cipher_valid/cipher_ready/cipher, each a
// 64-bit block as two 32-bit words, and the decrypted items leave on
// plain_valid/plain_ready/plain in the same order. The 128-bit key sits in
// four 32-bit registers at byte addresses 0, 4, 8 and 12 of the APB port.
// Keys should be written only while no item is in flight.
// Each round is split into two half-rounds, and each half-round is one
// register stage. One item can enter in every cycle unless a receiver stall
// has backed up to the first stage; the adder, XOR and subtract chain of
// one half-round sets the clock period.
// Reset clears all stage valid bits and the key registers to zero.
// When the receiver stalls, each stage holds its item and empty stages
// further up keep filling, so input is still taken until the pipeline is
// full; no item is lost or repeated.
module tea_block_decrypt_core
    import tea_dec_pkg::*;
#(
    parameter int ROUND_COUNT = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cipher_valid,
    output logic        cipher_ready,
    input  cipher_t     cipher,
    output logic        plain_valid,
    input  logic        plain_ready,
    output plain_t      plain,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int STAGE_COUNT = 2 * ROUND_COUNT;

    logic [31:0] key0_reg;
    logic [31:0] key1_reg;
    logic [31:0] key2_reg;
    logic [31:0] key3_reg;
    logic        cfg_write;
    reg_idx_t    cfg_idx;

    logic       link_valid [STAGE_COUNT+1];
    logic       link_ready [STAGE_COUNT+1];
    word_pair_t link_data  [STAGE_COUNT+1];

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= '0;
            key1_reg <= '0;
            key2_reg <= '0;
            key3_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_KEY_WORD_0: key0_reg <= pwdata;
                REG_KEY_WORD_1: key1_reg <= pwdata;
                REG_KEY_WORD_2: key2_reg <= pwdata;
                REG_KEY_WORD_3: key3_reg <= pwdata;
                default:        key0_reg <= key0_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_KEY_WORD_0: prdata = key0_reg;
            REG_KEY_WORD_1: prdata = key1_reg;
            REG_KEY_WORD_2: prdata = key2_reg;
            REG_KEY_WORD_3: prdata = key3_reg;
            default:        prdata = '0;
        endcase
    end

    assign link_valid[0]     = cipher_valid;
    assign cipher_ready      = link_ready[0];
    assign link_data[0].left  = cipher.cipher_left;
    assign link_data[0].right = cipher.cipher_right;

    for (genvar i = 0; i < STAGE_COUNT; i++)
    begin : g_stage
        localparam logic [31:0] ROUND_SUM =
            32'(64'(TEA_DELTA) * 64'(ROUND_COUNT - i / 2));
        localparam bit FIRST_HALF = ((i % 2) == 0);

        tea_dec_half_round #(
            .UPDATE_RIGHT (FIRST_HALF)
        ) u_half_round (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (link_valid[i]),
            .up_ready   (link_ready[i]),
            .up_data    (link_data[i]),
            .down_valid (link_valid[i+1]),
            .down_ready (link_ready[i+1]),
            .down_data  (link_data[i+1]),
            .key_shl    (FIRST_HALF ? key2_reg : key0_reg),
            .key_shr    (FIRST_HALF ? key3_reg : key1_reg),
            .round_sum  (ROUND_SUM)
        );
    end

    assign plain_valid             = link_valid[STAGE_COUNT];
    assign link_ready[STAGE_COUNT] = plain_ready;
    assign plain.plain_left        = link_data[STAGE_COUNT].left;
    assign plain.plain_right       = link_data[STAGE_COUNT].right;

endmodule

### rtl/core/tea_dec_chk.sv
// Port-level assertion checker for the TEA decryption core, with its bind.
module tea_dec_chk
    import tea_dec_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cipher_valid,
    input logic        cipher_ready,
    input cipher_t     cipher,
    input logic        plain_valid,
    input logic        plain_ready,
    input plain_t      plain,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    a_plain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        plain_valid && !plain_ready |=> plain_valid)
        else $error("Output item dropped while stalled.");

    a_plain_stable: assert property (@(posedge clk) disable iff (!rst_n)
        plain_valid && !plain_ready |=> $stable(plain))
        else $error("Output item changed while stalled.");

    a_input_open: assert property (@(posedge clk) disable iff (!rst_n)
        (!plain_valid || plain_ready) |-> cipher_ready)
        else $error("Input blocked while the output stage can move.");

    a_key_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready
        |=> (paddr[3:2] != $past(paddr[3:2]) || prdata == $past(pwdata)))
        else $error("Key register does not read back the written value.");

endmodule

bind tea_block_decrypt_core tea_dec_chk u_tea_dec_chk (.*);
